// ===== sv/mcq_pkg.sv =====
// Shared types and codes for the motion command queue sequencer.
`timescale 1ns / 1ps
`default_nettype none
package mcq_pkg;

	// request codes carried by func
	localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_START   = 2'd2;
	localparam logic [1:0] FUNC_STOP    = 2'd3;

	// stored action kinds
	localparam logic [1:0] KIND_MOVE = 2'd0;
	localparam logic [1:0] KIND_TOOL = 2'd1;
	localparam logic [1:0] KIND_WAIT = 2'd2;

	// issued command codes
	localparam logic [1:0] ISSUE_NONE = 2'd0;
	localparam logic [1:0] ISSUE_MOVE = 2'd1;
	localparam logic [1:0] ISSUE_TOOL = 2'd2;

	// register index decoded from paddr[2]
	localparam logic REG_TOOL_CARRY = 1'b0;

	localparam int unsigned COUNT_OUT_W = 10;
	localparam int unsigned WAIT_ACC_W  = 17;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        amount;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== sv/mcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mcq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/motion_command_queue_sequencer.sv =====
// Top level: ring queue of motion actions with tick-driven issue and wait timer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per request:
//   enqueue an action, a time tick, start or stop processing. Output channel
//   (out_valid / out_stall) returns exactly one result transaction per
//   request: the issued command (if any), processing/waiting flags, whether
//   every action was stored, and the queue occupancy.
//   Timing: the result is registered at the accepting edge and is valid in
//   the next cycle, except a start, whose two appended actions share the one
//   queue write port; its result is registered in a second phase (second_q),
//   during which the input stalls.
//   Throughput: one transaction per cycle unless stalled by out_stall or a start.
//   The queue is a single-port-write RAM with registered read; the head entry
//   is prefetched every cycle, with a one-entry bypass for a write that lands
//   on the head slot in the same cycle.
//   The queue holds at most QUEUE_DEPTH-1 actions; extra ones are dropped.
//   Reset clears pointers, flags, the wait timer and the tool carry
//   register. The queue memory is not cleared: only written slots are read.
//   When out_stall is high while a result is valid, the result register
//   holds and the input is stalled until the result moves.
`timescale 1ns / 1ps
`default_nettype none
module motion_command_queue_sequencer #(
	parameter int unsigned QUEUE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [1:0]         action_kind,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic [15:0]        amount,
	input  wire logic [7:0]         elapsed_ms,
	input  wire logic               motion_idle,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              issue_kind,
	output logic signed [31:0]      issue_x,
	output logic signed [31:0]      issue_y,
	output logic [15:0]             issue_tool_position,
	output logic                    processing,
	output logic                    waiting,
	output logic                    accepted,
	output logic [9:0]              queue_count
);

	import mcq_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	// ---------------- config register ----------------
	logic        cfg_wr;
	logic [11:0] tool_carry_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_TOOL_CARRY) ? {20'b0, tool_carry_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tool_carry_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_TOOL_CARRY) begin
			tool_carry_q <= pwdata[11:0];
		end
	end

	// ---------------- state ----------------
	logic [PTR_W-1:0]      head_q, tail_q, head_d, tail_d, tail_nxt, head_nxt;
	logic                  running_q, running_d;
	logic                  in_wait_q, in_wait_d;
	logic [15:0]           wait_target_q, wait_target_d;
	logic [WAIT_ACC_W-1:0] wait_elapsed_q, wait_elapsed_d;
	logic                  second_q;   // second half of a start: push the home move
	logic                  start_ok_q, start_ok_d;

	// result register
	logic                  out_valid_q;
	logic [1:0]            issue_kind_q;
	logic signed [31:0]    issue_x_q, issue_y_q;
	logic [15:0]           issue_tool_q;
	logic                  processing_q, waiting_q, accepted_q;
	logic [9:0]            count_q;

	logic in_fire, load_out;

	assign in_stall = second_q | (out_valid_q & out_stall);
	assign in_fire  = in_valid & ~in_stall;
	assign load_out = second_q | (in_fire & (func != FUNC_START));

	// ---------------- queue memory ----------------
	entry_t           wr_entry, ram_rdata, byp_q, head_entry;
	logic             push_req, push_ok, full;
	logic             byp_valid_q;
	logic [ENTRY_W-1:0] ram_rd_bits;

	mcq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(tail_q),
		.wdata(wr_entry),
		.raddr(head_d),
		.rdata(ram_rd_bits)
	);

	assign ram_rdata  = entry_t'(ram_rd_bits);
	assign head_entry = byp_valid_q ? byp_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else begin
			byp_valid_q <= push_ok && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= wr_entry;
	end

	// ring pointer steps
	assign tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign full     = (tail_nxt == head_q);
	assign push_ok  = push_req & ~full;

	// ---------------- wait timer ----------------
	logic [WAIT_ACC_W:0]   wait_sum;
	logic [WAIT_ACC_W-1:0] wait_sat;
	logic                  wait_done;

	assign wait_sum  = {1'b0, wait_elapsed_q} + (WAIT_ACC_W + 1)'(elapsed_ms);
	assign wait_sat  = wait_sum[WAIT_ACC_W] ? '1 : wait_sum[WAIT_ACC_W-1:0];
	assign wait_done = (wait_sat >= WAIT_ACC_W'(wait_target_q));

	// ---------------- request decode ----------------
	logic [1:0]         iss_kind;
	logic signed [31:0] iss_x, iss_y;
	logic [15:0]        iss_tool;
	logic               ok;

	always_comb begin
		head_d         = head_q;
		running_d      = running_q;
		in_wait_d      = in_wait_q;
		wait_target_d  = wait_target_q;
		wait_elapsed_d = wait_elapsed_q;
		start_ok_d     = start_ok_q;
		push_req       = 1'b0;
		wr_entry       = '0;
		iss_kind       = ISSUE_NONE;
		iss_x          = '0;
		iss_y          = '0;
		iss_tool       = '0;

		if (second_q) begin
			// home move to 0,0
			push_req      = 1'b1;
			wr_entry.kind = KIND_MOVE;
		end else if (in_fire) begin
			unique case (func)
				FUNC_ENQUEUE: begin
					if (action_kind == KIND_MOVE) begin
						push_req      = 1'b1;
						wr_entry.kind = KIND_MOVE;
						wr_entry.x    = target_x;
						wr_entry.y    = target_y;
					end else if (action_kind == KIND_TOOL || action_kind == KIND_WAIT) begin
						push_req        = 1'b1;
						wr_entry.kind   = action_kind;
						wr_entry.amount = amount;
					end
				end
				FUNC_START: begin
					running_d       = 1'b1;
					push_req        = 1'b1;
					wr_entry.kind   = KIND_TOOL;
					wr_entry.amount = {4'b0, tool_carry_q};
				end
				FUNC_STOP: begin
					running_d = 1'b0;
				end
				FUNC_TICK: begin
					if (running_q) begin
						if (in_wait_q) begin
							wait_elapsed_d = wait_sat;
							if (wait_done) begin
								in_wait_d = 1'b0;
							end
						end else if (motion_idle) begin
							if (head_q == tail_q) begin
								running_d = 1'b0;
							end else begin
								head_d = head_nxt;
								priority if (head_entry.kind == KIND_MOVE) begin
									iss_kind = ISSUE_MOVE;
									iss_x    = head_entry.x;
									iss_y    = head_entry.y;
								end else if (head_entry.kind == KIND_TOOL) begin
									iss_kind = ISSUE_TOOL;
									iss_tool = head_entry.amount;
								end else if (head_entry.kind == KIND_WAIT) begin
									in_wait_d      = 1'b1;
									wait_target_d  = head_entry.amount;
									wait_elapsed_d = '0;
								end
							end
						end
					end
				end
			endcase
		end

		if (in_fire && func == FUNC_START) begin
			start_ok_d = push_ok;
		end

		tail_d = push_ok ? tail_nxt : tail_q;

		// every attempted store must land
		if (second_q) begin
			ok = start_ok_q & push_ok;
		end else if (func == FUNC_ENQUEUE) begin
			ok = push_ok;
		end else begin
			ok = 1'b1;
		end
	end

	// occupancy after this transaction, masked to the 10-bit result field
	logic [CNT_W-1:0]             held;
	logic [CNT_W+COUNT_OUT_W-1:0] held_ext;

	assign held = (tail_d >= head_d)
		? ({1'b0, tail_d} - {1'b0, head_d})
		: ({1'b0, tail_d} + CNT_W'(QUEUE_DEPTH) - {1'b0, head_d});
	assign held_ext = {{COUNT_OUT_W{1'b0}}, held};

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			tail_q         <= '0;
			running_q      <= 1'b0;
			in_wait_q      <= 1'b0;
			wait_target_q  <= '0;
			wait_elapsed_q <= '0;
			second_q       <= 1'b0;
			start_ok_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			head_q         <= head_d;
			tail_q         <= tail_d;
			running_q      <= running_d;
			in_wait_q      <= in_wait_d;
			wait_target_q  <= wait_target_d;
			wait_elapsed_q <= wait_elapsed_d;
			start_ok_q     <= start_ok_d;
			second_q       <= in_fire && (func == FUNC_START);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			issue_kind_q <= iss_kind;
			issue_x_q    <= iss_x;
			issue_y_q    <= iss_y;
			issue_tool_q <= iss_tool;
			processing_q <= running_d;
			waiting_q    <= in_wait_d;
			accepted_q   <= ok;
			count_q      <= held_ext[COUNT_OUT_W-1:0];
		end
	end

	assign out_valid           = out_valid_q;
	assign issue_kind          = issue_kind_q;
	assign issue_x             = issue_x_q;
	assign issue_y             = issue_y_q;
	assign issue_tool_position = issue_tool_q;
	assign processing          = processing_q;
	assign waiting             = waiting_q;
	assign accepted            = accepted_q;
	assign queue_count         = count_q;

	// ---------------- assertions ----------------
	a_start_two_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func == FUNC_START) |=> second_q)
		else $error("start did not enter its second phase");

	a_second_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |=> (!second_q && out_valid_q))
		else $error("start second phase did not complete in one cycle");

	a_issue_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && issue_kind_q != ISSUE_NONE) |-> (processing_q && !waiting_q))
		else $error("command issued while not processing or while waiting");

endmodule
`default_nettype wire
